// ===== sv/csr_sparse_matrix_vector_multiply_unit_assert.svh =====
// Assertion macros for the CSR sparse matrix-vector multiply unit.
// Included by the top level; no other dependencies.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CSMV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CSMV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSMV_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define CSMV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/csmv_pkg.sv =====
// Shared constants and types for the CSR sparse matrix-vector multiply unit.
// No dependencies.
package csmv_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 64;
    localparam int VLEN_W   = 13;

    localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_NONZERO = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EMPTY   = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Control travelling alongside the product into the accumulate stage.
    typedef struct packed {
        logic                valid;
        logic [OPCODE_W-1:0] opcode;
        logic                last;
        logic                bad;
    } acc_cmd_t;

endpackage

// ===== sv/csmv_if.sv =====
// Valid/ready channel interfaces for input items and row results.
// Depends on csmv_pkg.
interface csmv_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [csmv_pkg::OPCODE_W-1:0]          opcode;
    logic [csmv_pkg::INDEX_W-1:0]           index;
    logic signed [csmv_pkg::VALUE_W-1:0]    value;
    logic                                   last_in_row;

    modport source (output valid, opcode, index, value, last_in_row, input ready);
    modport sink (input valid, opcode, index, value, last_in_row, output ready);
endinterface

interface csmv_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [csmv_pkg::SUM_W-1:0]      row_sum;
    logic                                   status;

    modport source (output valid, row_sum, status, input ready);
    modport sink (input valid, row_sum, status, output ready);
endinterface

// ===== sv/csr_sparse_matrix_vector_multiply_unit.sv =====
// Items pass the stage 1 registers, stage 2 and the accumulator's output register.
// Throughput: one transaction per cycle; the store takes at most one access per item.
// Stalls only while a result sits unaccepted in the output register.
// Reset (rst_n, asynchronous, active low) clears vec_len, the accumulator, the error
// flag and all valid bits; vector store contents are undefined until loaded.
// Depends on csmv_pkg, csmv_if, csmv_vec_store, csmv_accum and the assertion header.
`include "csr_sparse_matrix_vector_multiply_unit_assert.svh"

module csr_sparse_matrix_vector_multiply_unit #(
    parameter int VECTOR_DEPTH = 4096,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csmv_pkg::VLEN_W-1:0]     cfg_wdata,
    csmv_in_if.sink                         item,
    csmv_out_if.source                      result
);

    localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int PROD_W = 2 * VALUE_WIDTH;

    // The whole pipeline moves together; it only holds when the output register
    // still carries a result that the downstream side has not taken.
    logic advance;
    logic accept;

    logic [csmv_pkg::VLEN_W-1:0] vec_len_reg;

    // Stage 0 decode, done on the accepting edge.
    logic                   in_depth;
    logic                   col_bad;
    logic [ADDR_W-1:0]      store_addr;
    logic                   store_we;
    logic                   store_re;
    logic [VALUE_WIDTH-1:0] store_rdata;

    // Stage 1: the store read data arrives alongside these registers.
    logic                          s1_valid_reg;
    logic [csmv_pkg::OPCODE_W-1:0] s1_opcode_reg;
    logic                          s1_last_reg;
    logic                          s1_bad_reg;
    logic signed [VALUE_WIDTH-1:0] s1_val_reg;
    logic signed [PROD_W-1:0]      s1_prod;

    // Stage 2: registered product and its command for the accumulator.
    csmv_pkg::acc_cmd_t                s2_cmd_reg, s2_cmd_next;
    logic signed [csmv_pkg::SUM_W-1:0] s2_prod_reg;

    assign advance    = !result.valid || result.ready;
    assign item.ready = advance;
    assign accept     = item.valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            vec_len_reg <= cfg_wdata;
        end
    end

    // A column is bad when it reaches either vec_len or the physical store depth.
    // The same depth check drops loads aimed beyond the store.
    assign in_depth   = 32'(item.index) < 32'(VECTOR_DEPTH);
    assign col_bad    = !in_depth
                        || ({1'b0, item.index} >= vec_len_reg);
    assign store_addr = ADDR_W'(item.index);
    assign store_we   = accept && (item.opcode == csmv_pkg::OP_LOAD) && in_depth;
    assign store_re   = accept && (item.opcode == csmv_pkg::OP_NONZERO);

    // Loads write on the accepting edge and nonzeros read on theirs, so items
    // in order see each other's effect on the store without forwarding.
    csmv_vec_store #(
        .DEPTH  (VECTOR_DEPTH),
        .WIDTH  (VALUE_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .re    (store_re),
        .addr  (store_addr),
        .wdata (item.value[VALUE_WIDTH-1:0]),
        .rdata (store_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_opcode_reg <= item.opcode;
            s1_last_reg   <= item.last_in_row;
            s1_bad_reg    <= col_bad;
            s1_val_reg    <= item.value[VALUE_WIDTH-1:0];
        end
    end

    // Signed Q16.16 by Q16.16 gives Q32.32; the size cast sign-extends to 64 bits.
    assign s1_prod = s1_val_reg * $signed(store_rdata);

    always_comb
    begin
        s2_cmd_next.valid  = s1_valid_reg;
        s2_cmd_next.opcode = s1_opcode_reg;
        s2_cmd_next.last   = s1_last_reg;
        s2_cmd_next.bad    = s1_bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_cmd_reg <= '0;
        end
        else if (advance)
        begin
            s2_cmd_reg <= s2_cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_prod_reg <= csmv_pkg::SUM_W'(s1_prod);
        end
    end

    // The accumulator applies loads, nonzeros and empty rows in order, so the
    // sticky error flag and its clearing by loads follow transaction order.
    csmv_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (s2_cmd_reg),
        .prod    (s2_prod_reg),
        .result  (result)
    );

    `CSMV_ASSERT_NOW(a_err_row_zero, clk, rst_n, result.valid && result.status, result.row_sum == '0)
    `CSMV_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, result.valid && !result.ready, !item.ready)
    `CSMV_ASSERT_NEXT(a_stage1_holds, clk, rst_n, !advance, $stable(s1_valid_reg) && $stable(s2_cmd_reg))

endmodule

// ===== sv/csmv_vec_store.sv =====
// Dense vector store: single-port synchronous RAM with registered read data.
// No dependencies.
module csmv_vec_store #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/csmv_accum.sv =====
// Row accumulator with saturation, sticky error flag and output register.
// Depends on csmv_pkg and csmv_if.
module csmv_accum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  csmv_pkg::acc_cmd_t                 cmd,
    input  logic signed [csmv_pkg::SUM_W-1:0]  prod,
    csmv_out_if.source                         result
);

    logic signed [csmv_pkg::SUM_W-1:0] acc_reg, acc_next;
    logic                              err_reg, err_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [csmv_pkg::SUM_W-1:0] out_sum_reg, out_sum_next;
    logic                              out_status_reg, out_status_next;
    logic signed [csmv_pkg::SUM_W:0]   wide_sum;
    logic signed [csmv_pkg::SUM_W-1:0] sat_sum;
    logic signed [csmv_pkg::SUM_W-1:0] added;
    logic                              err_upd;

    // Overflow shows as disagreement between the two top bits of the wide sum.
    always_comb
    begin
        wide_sum = {acc_reg[csmv_pkg::SUM_W-1], acc_reg} + {prod[csmv_pkg::SUM_W-1], prod};
        if (wide_sum[csmv_pkg::SUM_W] != wide_sum[csmv_pkg::SUM_W-1])
        begin
            sat_sum = wide_sum[csmv_pkg::SUM_W] ? csmv_pkg::SUM_MIN : csmv_pkg::SUM_MAX;
        end
        else
        begin
            sat_sum = wide_sum[csmv_pkg::SUM_W-1:0];
        end
    end

    always_comb
    begin
        acc_next        = acc_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;
        err_upd         = err_reg | cmd.bad;
        added           = cmd.bad ? acc_reg : sat_sum;
        if (advance)
        begin
            out_valid_next = 1'b0;
            if (cmd.valid)
            begin
                unique case (cmd.opcode)
                    csmv_pkg::OP_LOAD:
                    begin
                        err_next = 1'b0;
                    end
                    csmv_pkg::OP_NONZERO:
                    begin
                        err_next = err_upd;
                        if (cmd.last)
                        begin
                            acc_next        = '0;
                            out_valid_next  = 1'b1;
                            out_sum_next    = err_upd ? '0 : added;
                            out_status_next = err_upd;
                        end
                        else
                        begin
                            acc_next = added;
                        end
                    end
                    csmv_pkg::OP_EMPTY:
                    begin
                        acc_next        = '0;
                        out_valid_next  = 1'b1;
                        out_sum_next    = '0;
                        out_status_next = err_reg;
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.row_sum = out_sum_reg;
    assign result.status  = out_status_reg;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the CSR sparse matrix-vector multiply unit.
// Depends on csmv_pkg, csmv_if and the csr_sparse_matrix_vector_multiply_unit RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD     = 10;
    localparam int STORE_DEPTH    = 4096;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int SEGMENT_ITEMS  = 186;

    // The fourth opcode is not decoded by the block and must leave it untouched.
    localparam logic [csmv_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [csmv_pkg::OPCODE_W-1:0] opcode;
        logic [csmv_pkg::INDEX_W-1:0]  index;
        logic [csmv_pkg::VALUE_W-1:0]  value;
        logic                          last_in_row;
    } spmv_item_t;

    typedef struct packed {
        logic [csmv_pkg::SUM_W-1:0] row_sum;
        logic                       status;
    } row_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [csmv_pkg::VLEN_W-1:0]   cfg_wdata;

    csmv_in_if  item_if ();
    csmv_out_if result_if ();

    csr_sparse_matrix_vector_multiply_unit #(
        .VECTOR_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH  (csmv_pkg::VALUE_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_if),
        .result    (result_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Transactions waiting for the driver, and rows the predictor expects to see.
    spmv_item_t  item_backlog [$];
    row_result_t expected_rows [$];

    int unsigned issued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned fail_count     = 0;
    int unsigned quiet_cycles   = 0;
    bit          item_taken     = 1'b0;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Predictor state: the vector store, the running row sum, the sticky error
    // flag and the programmed vector length.
    logic [csmv_pkg::VALUE_W-1:0] vec_image [0:STORE_DEPTH-1];
    logic [csmv_pkg::SUM_W-1:0]   acc_image   = '0;
    logic                         sticky_err  = 1'b0;
    int unsigned                  len_image   = 0;

    // Generator bookkeeping, so that a column is only ever read once loaded.
    bit          written_map [0:STORE_DEPTH-1];
    int unsigned written_list [$];
    int unsigned gen_limit = 0;
    int unsigned seg_items = 0;

    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Applies one accepted transaction to the predictor and queues the row it emits.
    function automatic void predict_row_output(input spmv_item_t it);
        logic [csmv_pkg::SUM_W-1:0] product;
        logic [csmv_pkg::SUM_W:0]   total;
        row_result_t                row;
        int unsigned                limit;
        limit = (len_image < STORE_DEPTH) ? len_image : STORE_DEPTH;
        row.row_sum = '0;
        row.status  = 1'b0;
        case (it.opcode)
            csmv_pkg::OP_LOAD:
            begin
                vec_image[it.index] = it.value;
                sticky_err = 1'b0;
            end
            csmv_pkg::OP_NONZERO:
            begin
                if (it.index >= limit)
                begin
                    sticky_err = 1'b1;
                end
                else
                begin
                    // Sign-extended operands; the low 64 bits hold the exact Q32.32 product.
                    product = {{(csmv_pkg::SUM_W-csmv_pkg::VALUE_W){it.value[csmv_pkg::VALUE_W-1]}},
                               it.value} *
                              {{(csmv_pkg::SUM_W-csmv_pkg::VALUE_W)
                                   {vec_image[it.index][csmv_pkg::VALUE_W-1]}},
                               vec_image[it.index]};
                    total = {acc_image[csmv_pkg::SUM_W-1], acc_image} +
                            {product[csmv_pkg::SUM_W-1], product};
                    if (total[csmv_pkg::SUM_W] != total[csmv_pkg::SUM_W-1])
                        acc_image = total[csmv_pkg::SUM_W] ? csmv_pkg::SUM_MIN
                                                           : csmv_pkg::SUM_MAX;
                    else
                        acc_image = total[csmv_pkg::SUM_W-1:0];
                end
                if (it.last_in_row)
                begin
                    row.row_sum = sticky_err ? '0 : acc_image;
                    row.status  = sticky_err;
                    acc_image   = '0;
                    expected_rows.push_back(row);
                end
            end
            csmv_pkg::OP_EMPTY:
            begin
                acc_image  = '0;
                row.status = sticky_err;
                expected_rows.push_back(row);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void queue_item(input logic [csmv_pkg::OPCODE_W-1:0] op,
                                       input int unsigned col,
                                       input logic [csmv_pkg::VALUE_W-1:0] val,
                                       input bit last);
        spmv_item_t it;
        it.opcode      = op;
        it.index       = col[csmv_pkg::INDEX_W-1:0];
        it.value       = val;
        it.last_in_row = last;
        item_backlog.push_back(it);
        issued_count++;
        if (op == csmv_pkg::OP_LOAD && !written_map[col[csmv_pkg::INDEX_W-1:0]])
        begin
            written_map[col[csmv_pkg::INDEX_W-1:0]] = 1'b1;
            written_list.push_back(32'(col[csmv_pkg::INDEX_W-1:0]));
        end
        if (op != OP_UNUSED)
            seg_items++;
    endfunction

    // Extremes are favoured so that products are large and the accumulator saturates.
    function automatic logic [csmv_pkg::VALUE_W-1:0] pick_value(input bit heavy);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < (heavy ? 40 : 10))
            return 32'h8000_0000;
        if (roll < (heavy ? 80 : 20))
            return 32'h7FFF_FFFF;
        if (roll < (heavy ? 85 : 28))
            return roll[0] ? 32'h0001_0000 : 32'hFFFF_0000;
        return $urandom();
    endfunction

    // Picks an in-range or out-of-range column that has been loaded, loading one
    // first where no suitable entry has been written yet.
    function automatic int unsigned pick_column(input bit want_good);
        int unsigned lo;
        int unsigned hi;
        int unsigned col;
        int          tries;
        lo = want_good ? 0 : gen_limit;
        hi = want_good ? gen_limit - 1 : STORE_DEPTH - 1;
        for (tries = 0; tries < 8; tries++)
        begin
            col = written_list[$urandom_range(written_list.size() - 1)];
            if (col >= lo && col <= hi)
                return col;
        end
        col = $urandom_range(hi, lo);
        if (!written_map[col[csmv_pkg::INDEX_W-1:0]])
            queue_item(csmv_pkg::OP_LOAD, col, pick_value(1'b0), 1'b0);
        return col;
    endfunction

    task automatic write_vec_len(input int unsigned len);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len[csmv_pkg::VLEN_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        len_image = len;
        gen_limit = (len < STORE_DEPTH) ? len : STORE_DEPTH;
    endtask

    // Waits until every transaction has gone in and every row has come out, then
    // leaves time for loads and unfinished rows still inside the pipeline.
    task automatic settle();
        while (!(item_backlog.size() == 0 && accepted_count == issued_count &&
                 expected_rows.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic build_random_segment(input int unsigned target);
        int unsigned roll;
        int unsigned len;
        int unsigned k;
        bit          bad;
        seg_items = 0;
        while (seg_items < target)
        begin
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                len = $urandom_range(6, 1);
                for (k = 0; k < len; k++)
                    queue_item(csmv_pkg::OP_LOAD,
                               (gen_limit > 0 && $urandom_range(1)) ?
                                   $urandom_range(gen_limit - 1) :
                                   $urandom_range(STORE_DEPTH - 1),
                               pick_value(1'b0), 1'($urandom_range(1)));
            end
            else if (roll < 80)
            begin
                // Well-formed row; a few long ones with heavy values push into saturation.
                len = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
                for (k = 0; k < len; k++)
                begin
                    bad = (gen_limit == 0) ||
                          (gen_limit < STORE_DEPTH && $urandom_range(99) < 5);
                    queue_item(csmv_pkg::OP_NONZERO, pick_column(!bad), pick_value(len >= 10),
                               k == len - 1);
                end
            end
            else if (roll < 88)
            begin
                queue_item(csmv_pkg::OP_EMPTY, $urandom(), pick_value(1'b0),
                           1'($urandom_range(1)));
            end
            else if (roll < 95)
            begin
                // Row left open; an empty row afterwards must discard the partial sum.
                len = $urandom_range(4, 1);
                for (k = 0; k < len; k++)
                begin
                    bad = (gen_limit == 0) ||
                          (gen_limit < STORE_DEPTH && $urandom_range(99) < 5);
                    queue_item(csmv_pkg::OP_NONZERO, pick_column(!bad), pick_value(1'b0),
                               1'b0);
                end
                if ($urandom_range(1))
                    queue_item(csmv_pkg::OP_EMPTY, $urandom(), $urandom(),
                               1'($urandom_range(1)));
            end
            else
            begin
                queue_item(OP_UNUSED, $urandom(), $urandom(), 1'($urandom_range(1)));
            end
        end
    endtask

    // Driver: presents the next transaction at the falling edge and holds it until
    // the monitor has seen it accepted. The receiver's ready is randomised here too.
    always @(negedge clk)
    begin : item_driver
        spmv_item_t next_item;
        logic       hold;
        hold       = item_if.valid && !item_taken;
        item_taken = 1'b0;
        if (rst_n && !hold && item_backlog.size() != 0 &&
            $urandom_range(99) >= send_idle_pct)
        begin
            next_item = item_backlog.pop_front();
            item_if.opcode      <= next_item.opcode;
            item_if.index       <= next_item.index;
            item_if.value       <= next_item.value;
            item_if.last_in_row <= next_item.last_in_row;
            hold = 1'b1;
        end
        item_if.valid    <= hold;
        result_if.ready  <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: checks rows leaving the block, feeds accepted transactions to the
    // predictor, and ends the run if nothing moves for too long.
    always @(posedge clk)
    begin : txn_monitor
        row_result_t want;
        spmv_item_t  seen;
        bit          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
            begin
                moved = 1'b1;
                if (expected_rows.size() == 0)
                begin
                    log_failure($sformatf("row with none expected: sum %h status %b",
                                          result_if.row_sum, result_if.status));
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (result_if.row_sum !== want.row_sum || result_if.status !== want.status)
                        log_failure($sformatf("sum %h status %b, expected sum %h status %b",
                                              result_if.row_sum, result_if.status,
                                              want.row_sum, want.status));
                end
            end
            if (item_if.valid === 1'b1 && item_if.ready === 1'b1)
            begin
                moved            = 1'b1;
                seen.opcode      = item_if.opcode;
                seen.index       = item_if.index;
                seen.value       = item_if.value;
                seen.last_in_row = item_if.last_in_row;
                predict_row_output(seen);
                accepted_count++;
                item_taken = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned vec_len_plan [9];
        int          seg;
        vec_len_plan = '{4096, 0, 1, 2048, 4096, 777, 4096, 16, 3000};
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        item_if.valid        = 1'b0;
        item_if.opcode       = csmv_pkg::OP_LOAD;
        item_if.index        = '0;
        item_if.value        = '0;
        item_if.last_in_row  = 1'b0;
        result_if.ready      = 1'b0;
        send_idle_pct        = 8;
        recv_stall_pct       = 57;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with a vector length of sixteen.
        write_vec_len(16);
        queue_item(csmv_pkg::OP_LOAD, 0, 32'h8000_0000, 1'b0);
        queue_item(csmv_pkg::OP_LOAD, 1, 32'h7FFF_FFFF, 1'b0);
        queue_item(csmv_pkg::OP_LOAD, 15, 32'h0001_0000, 1'b0);
        queue_item(csmv_pkg::OP_LOAD, 4095, 32'hFFFF_FFFF, 1'b1);
        queue_item(csmv_pkg::OP_NONZERO, 15, 32'h0003_0000, 1'b1);
        // Two products of the most negative values overflow upwards.
        queue_item(csmv_pkg::OP_NONZERO, 0, 32'h8000_0000, 1'b0);
        queue_item(csmv_pkg::OP_NONZERO, 0, 32'h8000_0000, 1'b1);
        // Three large negative products overflow downwards.
        queue_item(csmv_pkg::OP_NONZERO, 0, 32'h7FFF_FFFF, 1'b0);
        queue_item(csmv_pkg::OP_NONZERO, 0, 32'h7FFF_FFFF, 1'b0);
        queue_item(csmv_pkg::OP_NONZERO, 0, 32'h7FFF_FFFF, 1'b1);
        // A partial row dropped by an empty row.
        queue_item(csmv_pkg::OP_NONZERO, 1, 32'h7FFF_FFFF, 1'b0);
        queue_item(csmv_pkg::OP_EMPTY, 0, 32'h0, 1'b0);
        queue_item(csmv_pkg::OP_NONZERO, 15, 32'h1234_5678, 1'b1);
        // Out-of-range column: the error sticks across rows and the unused opcode.
        queue_item(csmv_pkg::OP_NONZERO, 4095, 32'h0000_0005, 1'b0);
        queue_item(csmv_pkg::OP_NONZERO, 15, 32'h0001_0000, 1'b1);
        queue_item(csmv_pkg::OP_EMPTY, 4095, 32'hFFFF_FFFF, 1'b1);
        queue_item(OP_UNUSED, 4095, 32'hFFFF_FFFF, 1'b1);
        queue_item(csmv_pkg::OP_NONZERO, 1, 32'h0001_0000, 1'b1);
        // A load clears the error.
        queue_item(csmv_pkg::OP_LOAD, 2, 32'h0, 1'b0);
        queue_item(csmv_pkg::OP_NONZERO, 2, 32'h7FFF_FFFF, 1'b1);
        // The first column past the vector length.
        queue_item(csmv_pkg::OP_LOAD, 16, 32'h0001_0000, 1'b0);
        queue_item(csmv_pkg::OP_NONZERO, 16, 32'h0000_0001, 1'b1);
        queue_item(csmv_pkg::OP_LOAD, 3, 32'hAAAA_AAAA, 1'b0);
        queue_item(csmv_pkg::OP_NONZERO, 3, 32'h5555_5555, 1'b1);
        settle();

        // Random part: three segments per idling pattern, each under its own length.
        for (seg = 0; seg < 9; seg++)
        begin
            if (seg == 3)
            begin
                send_idle_pct  = 57;
                recv_stall_pct = 8;
            end
            else if (seg == 6)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_vec_len(vec_len_plan[seg]);
            build_random_segment(SEGMENT_ITEMS);
            settle();
        end

        if (fail_count == 0 && expected_rows.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== csr_sparse_matrix_vector_multiply_unit.f =====
+incdir+sv
sv/csmv_pkg.sv
sv/csmv_if.sv
sv/csmv_vec_store.sv
sv/csmv_accum.sv
sv/csr_sparse_matrix_vector_multiply_unit.sv
sim/tb_top.sv
